/* rtl/sfc_pkg.sv */
// Shared constants, types and state codes for the stereo FIR convolver.
package sfc_pkg;

   // Field widths fixed by the request and result formats
   localparam int unsigned SAMPLE_BITS    = 16;
   localparam int unsigned GAIN_BITS      = 16;
   localparam int unsigned GAIN_FRAC      = 12;
   localparam int unsigned COUNT_BITS     = 13;
   localparam int unsigned INDEX_BITS     = 12;
   localparam int unsigned ROUND_SHIFT    = SAMPLE_BITS - 1 + GAIN_FRAC;

   // Channels, one cell each
   localparam int unsigned CHANNELS = 2;
   localparam int unsigned CH_LEFT  = 0;
   localparam int unsigned CH_RIGHT = 1;

   // Register file
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_COUNT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN      = 1'b1;
   localparam logic [COUNT_BITS-1:0]     TAP_COUNT_RESET = 13'd1;
   localparam logic [GAIN_BITS-1:0]      GAIN_RESET      = 16'd4096;

   // Request modes
   localparam logic MODE_TAP    = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // Command token passed along the row of cells
   typedef struct packed {
      logic clr;      // zero one entry of every store
      logic wr_tap;   // write tap store
      logic wr_hist;  // write history store
      logic rd;       // read one history/tap pair
      logic first;    // first pair of a sum
      logic last;     // last pair of a sum
   } ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TAP,
      ST_HIST,
      ST_RUN,
      ST_WAIT,
      ST_HOLD
   } seq_state_type;

endpackage

/* rtl/sfc_cell.sv */
// One channel cell: tap and history stores, multiply-accumulate and output scaling.
module sfc_cell import sfc_pkg::*; #(
   parameter  int unsigned MAX_TAPS  = 4096,
   localparam int unsigned ADDR_BITS = $clog2(MAX_TAPS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               up_ctl,
   input  logic [ADDR_BITS-1:0]  up_wr_addr,
   input  logic [ADDR_BITS-1:0]  up_rd_hist,
   input  logic [ADDR_BITS-1:0]  up_rd_tap,
   input  sample_type            tap_wdata,
   input  sample_type            hist_wdata,
   input  sample_type            bus,
   input  logic [GAIN_BITS-1:0]  gain,
   output ctl_type               dn_ctl,
   output logic [ADDR_BITS-1:0]  dn_wr_addr,
   output logic [ADDR_BITS-1:0]  dn_rd_hist,
   output logic [ADDR_BITS-1:0]  dn_rd_tap,
   output sample_type            result,
   output logic                  done
);

   localparam int unsigned PROD_BITS    = 2 * SAMPLE_BITS;
   localparam int unsigned ACC_BITS     = PROD_BITS + $clog2(MAX_TAPS);
   localparam int unsigned LO_BITS      = ACC_BITS / 2;
   localparam int unsigned HI_BITS      = ACC_BITS - LO_BITS;
   localparam int unsigned GW           = GAIN_BITS + 1;
   localparam int unsigned LO_PROD_BITS = LO_BITS + 1 + GW;
   localparam int unsigned HI_PROD_BITS = HI_BITS + GW;
   localparam int unsigned FULL_BITS    = ACC_BITS + GW;
   localparam int unsigned SC_BITS      = FULL_BITS - ROUND_SHIFT;
   localparam int unsigned SUM_BITS     = SC_BITS + 1;
   localparam logic [FULL_BITS-1:0] ROUND_HALF = FULL_BITS'(1) << (ROUND_SHIFT - 1);
   localparam logic signed [SUM_BITS-1:0] SAT_MAX = SUM_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic signed [SUM_BITS-1:0] SAT_MIN = ~SAT_MAX;

   sample_type                     tap_mem [MAX_TAPS];
   sample_type                     hist_mem [MAX_TAPS];
   sample_type                     hist_rd_ff;
   sample_type                     tap_rd_ff;
   ctl_type                        ctl_ff;
   logic [ADDR_BITS-1:0]           wr_addr_ff;
   logic [ADDR_BITS-1:0]           rd_hist_ff;
   logic [ADDR_BITS-1:0]           rd_tap_ff;
   logic signed [PROD_BITS-1:0]    prod_in;
   logic signed [PROD_BITS-1:0]    prod_ff;
   logic                           mvld_ff;
   logic                           mfirst_ff;
   logic                           mlast_ff;
   logic signed [ACC_BITS-1:0]     acc_in;
   logic signed [ACC_BITS-1:0]     acc_ff;
   logic                           acc_done_ff;
   logic signed [LO_PROD_BITS-1:0] lo_prod_in;
   logic signed [LO_PROD_BITS-1:0] lo_prod_ff;
   logic signed [HI_PROD_BITS-1:0] hi_prod_in;
   logic signed [HI_PROD_BITS-1:0] hi_prod_ff;
   logic                           f1_vld_ff;
   logic signed [FULL_BITS-1:0]    full_in;
   logic signed [SC_BITS-1:0]      sc_ff;
   logic                           f2_vld_ff;
   logic signed [SUM_BITS-1:0]     sum_in;
   sample_type                     result_in;
   sample_type                     result_ff;
   logic                           done_ff;

   // Stores: clear sweep, tap write and history write share the write port
   always_ff @(posedge clock) begin
      if (up_ctl.clr) begin
         tap_mem[up_wr_addr]  <= '0;
         hist_mem[up_wr_addr] <= '0;
      end else begin
         if (up_ctl.wr_tap) begin
            tap_mem[up_wr_addr] <= tap_wdata;
         end
         if (up_ctl.wr_hist) begin
            hist_mem[up_wr_addr] <= hist_wdata;
         end
      end
   end

   // Registered read of one history/tap pair
   always_ff @(posedge clock) begin
      if (up_ctl.rd) begin
         hist_rd_ff <= hist_mem[up_rd_hist];
         tap_rd_ff  <= tap_mem[up_rd_tap];
      end
   end

   // Token registered and handed on to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= up_wr_addr;
      rd_hist_ff <= up_rd_hist;
      rd_tap_ff  <= up_rd_tap;
   end

   // Product stage
   assign prod_in = hist_rd_ff * tap_rd_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvld_ff   <= 1'b0;
         mfirst_ff <= 1'b0;
         mlast_ff  <= 1'b0;
      end else begin
         mvld_ff   <= ctl_ff.rd;
         mfirst_ff <= ctl_ff.first;
         mlast_ff  <= ctl_ff.last;
      end
   end

   // Accumulate stage
   always_comb begin
      acc_in = acc_ff;
      if (mvld_ff) begin
         if (mfirst_ff) begin
            acc_in = ACC_BITS'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_BITS'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_done_ff <= 1'b0;
         f1_vld_ff   <= 1'b0;
         f2_vld_ff   <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         acc_done_ff <= mvld_ff & mlast_ff;
         f1_vld_ff   <= acc_done_ff;
         f2_vld_ff   <= f1_vld_ff;
         done_ff     <= f2_vld_ff;
      end
   end

   // Gain: two partial products over the lower and upper halves of the sum
   assign lo_prod_in = $signed({1'b0, acc_ff[LO_BITS-1:0]}) * $signed({1'b0, gain});
   assign hi_prod_in = $signed(acc_ff[ACC_BITS-1:LO_BITS]) * $signed({1'b0, gain});

   always_ff @(posedge clock) begin
      if (acc_done_ff) begin
         lo_prod_ff <= lo_prod_in;
         hi_prod_ff <= hi_prod_in;
      end
   end

   // Recombine, round half up and drop the fraction (floor shift)
   assign full_in = (FULL_BITS'(hi_prod_ff) <<< LO_BITS) + FULL_BITS'(lo_prod_ff)
                    + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (f1_vld_ff) begin
         sc_ff <= full_in[FULL_BITS-1:ROUND_SHIFT];
      end
   end

   // Add bus value and saturate
   assign sum_in = SUM_BITS'(sc_ff) + SUM_BITS'(bus);

   always_comb begin
      if (sum_in > SAT_MAX) begin
         result_in = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (sum_in < SAT_MIN) begin
         result_in = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         result_in = sum_in[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (f2_vld_ff) begin
         result_ff <= result_in;
      end
   end

   assign dn_ctl     = ctl_ff;
   assign dn_wr_addr = wr_addr_ff;
   assign dn_rd_hist = rd_hist_ff;
   assign dn_rd_tap  = rd_tap_ff;
   assign result     = result_ff;
   assign done       = done_ff;

endmodule

/* rtl/sfc_seq.sv */
// Sequencer: clear sweep after reset, tap and history writes, tap walk and result hand-off.
module sfc_seq import sfc_pkg::*; #(
   parameter  int unsigned MAX_TAPS  = 4096,
   localparam int unsigned ADDR_BITS = $clog2(MAX_TAPS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_mode,
   input  logic [INDEX_BITS-1:0] req_tap_index,
   output logic                  req_ready,
   input  logic [COUNT_BITS-1:0] tap_count,
   input  logic                  out_free,
   input  logic                  row_done,
   output logic                  rsp_load,
   output ctl_type               ctl,
   output logic [ADDR_BITS-1:0]  wr_addr,
   output logic [ADDR_BITS-1:0]  rd_hist_addr,
   output logic [ADDR_BITS-1:0]  rd_tap_addr
);

   localparam int unsigned LEN_BITS = $clog2(MAX_TAPS + 1);
   localparam int unsigned CMP_BITS = (LEN_BITS > COUNT_BITS) ? LEN_BITS : COUNT_BITS;
   localparam int unsigned IDX_BITS = (LEN_BITS > INDEX_BITS) ? LEN_BITS : INDEX_BITS;
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(MAX_TAPS - 1);

   seq_state_type         state_ff;
   seq_state_type         state_in;
   logic [ADDR_BITS-1:0]  i_ff;
   logic [ADDR_BITS-1:0]  i_in;
   logic [ADDR_BITS-1:0]  pos_ff;
   logic [ADDR_BITS-1:0]  pos_in;
   logic [ADDR_BITS-1:0]  wp_ff;
   logic [ADDR_BITS-1:0]  wp_in;
   logic [ADDR_BITS-1:0]  tap_addr_ff;
   logic [ADDR_BITS-1:0]  tap_addr_in;
   logic                  tap_ok_ff;
   logic                  tap_ok_in;
   logic [CMP_BITS-1:0]   tc_wide;
   logic [LEN_BITS-1:0]   eff_len;
   logic [LEN_BITS-1:0]   len_m1;
   logic [IDX_BITS-1:0]   idx_wide;
   logic                  accept;
   logic                  run_last;

   // Effective ring length: zero counts as one, capped at the store depth
   assign tc_wide = CMP_BITS'(tap_count);

   always_comb begin
      if (tc_wide == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (tc_wide > CMP_BITS'(MAX_TAPS)) begin
         eff_len = LEN_BITS'(MAX_TAPS);
      end else begin
         eff_len = tc_wide[LEN_BITS-1:0];
      end
   end

   assign len_m1   = eff_len - LEN_BITS'(1);
   assign idx_wide = IDX_BITS'(req_tap_index);
   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign run_last = (LEN_BITS'(i_ff) == len_m1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (i_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_mode == MODE_TAP) ? ST_TAP : ST_HIST;
            end
         end
         ST_TAP:  state_in = ST_IDLE;
         ST_HIST: state_in = ST_RUN;
         ST_RUN: begin
            if (run_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (row_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Counters and pointers
   always_comb begin
      i_in        = i_ff;
      pos_in      = pos_ff;
      wp_in       = wp_ff;
      tap_addr_in = tap_addr_ff;
      tap_ok_in   = tap_ok_ff;
      unique case (state_ff)
         ST_CLEAR: i_in = i_ff + ADDR_BITS'(1);
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_TAP) begin
                  tap_addr_in = idx_wide[ADDR_BITS-1:0];
                  tap_ok_in   = (idx_wide < IDX_BITS'(MAX_TAPS));
               end else if (LEN_BITS'(wp_ff) >= eff_len) begin
                  // ring was shortened under the pointer
                  wp_in = '0;
               end
            end
         end
         ST_HIST: begin
            pos_in = wp_ff;
            i_in   = '0;
            if (LEN_BITS'(wp_ff) + LEN_BITS'(1) >= eff_len) begin
               wp_in = '0;
            end else begin
               wp_in = wp_ff + ADDR_BITS'(1);
            end
         end
         ST_RUN: begin
            i_in = i_ff + ADDR_BITS'(1);
            if (pos_ff == '0) begin
               pos_in = len_m1[ADDR_BITS-1:0];
            end else begin
               pos_in = pos_ff - ADDR_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   // Outputs
   always_comb begin
      ctl          = '0;
      wr_addr      = i_ff;
      rd_hist_addr = pos_ff;
      rd_tap_addr  = i_ff;
      req_ready    = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: ctl.clr = 1'b1;
         ST_IDLE:  req_ready = 1'b1;
         ST_TAP: begin
            ctl.wr_tap = tap_ok_ff;
            wr_addr    = tap_addr_ff;
         end
         ST_HIST: begin
            ctl.wr_hist = 1'b1;
            wr_addr     = wp_ff;
         end
         ST_RUN: begin
            ctl.rd    = 1'b1;
            ctl.first = (i_ff == '0);
            ctl.last  = run_last;
         end
         ST_HOLD:  rsp_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         i_ff     <= '0;
         wp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         wp_ff    <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      tap_addr_ff <= tap_addr_in;
      tap_ok_ff   <= tap_ok_in;
   end

endmodule

/* rtl/stereo_fir_convolver_core.sv */
// Stereo FIR convolver: a sequencer driving a row of two channel cells.
// Sample request: the result follows the walk of L tap pairs (L = effective tap count); a new
//   request is taken only once the result is loaded; the walk reads one tap pair per channel per cycle.
// Tap request: no result; a new request is taken only after the tap write.
// Reset (synchronous, active high): clearing pass of all stores with
//   req_ready low; registers return to tap count 1 and unity gain.
module stereo_fir_convolver_core import sfc_pkg::*; #(
   parameter int unsigned MAX_TAPS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_mode,
   input  logic [INDEX_BITS-1:0]     req_tap_index,
   input  logic signed [SAMPLE_BITS-1:0] req_tap_left,
   input  logic signed [SAMPLE_BITS-1:0] req_tap_right,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_left,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_right,
   input  logic signed [SAMPLE_BITS-1:0] req_bus_left,
   input  logic signed [SAMPLE_BITS-1:0] req_bus_right,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_right,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int unsigned ADDR_BITS = $clog2(MAX_TAPS);
   localparam int unsigned DONE_LAG  = 5;

   logic [COUNT_BITS-1:0] tap_count_ff;
   logic [GAIN_BITS-1:0]  gain_ff;
   sample_type            tap_wd_ff  [CHANNELS];
   sample_type            hist_wd_ff [CHANNELS];
   sample_type            bus_ff     [CHANNELS];
   ctl_type               tok_ctl     [CHANNELS+1];
   logic [ADDR_BITS-1:0]  tok_wr_addr [CHANNELS+1];
   logic [ADDR_BITS-1:0]  tok_rd_hist [CHANNELS+1];
   logic [ADDR_BITS-1:0]  tok_rd_tap  [CHANNELS+1];
   sample_type            cell_result [CHANNELS];
   logic                  cell_done   [CHANNELS];
   logic                  rsp_load;
   logic                  out_free;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   sample_type            rsp_left_ff;
   sample_type            rsp_right_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
         gain_ff      <= GAIN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TAP_COUNT: tap_count_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_GAIN:      gain_ff      <= csr_wdata[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Request payload, held for the whole request
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         tap_wd_ff[CH_LEFT]   <= req_tap_left;
         tap_wd_ff[CH_RIGHT]  <= req_tap_right;
         hist_wd_ff[CH_LEFT]  <= req_sample_left;
         hist_wd_ff[CH_RIGHT] <= req_sample_right;
         bus_ff[CH_LEFT]      <= req_bus_left;
         bus_ff[CH_RIGHT]     <= req_bus_right;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   sfc_seq #(
      .MAX_TAPS (MAX_TAPS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_mode      (req_mode),
      .req_tap_index (req_tap_index),
      .req_ready     (req_ready),
      .tap_count     (tap_count_ff),
      .out_free      (out_free),
      .row_done      (cell_done[CHANNELS-1]),
      .rsp_load      (rsp_load),
      .ctl           (tok_ctl[0]),
      .wr_addr       (tok_wr_addr[0]),
      .rd_hist_addr  (tok_rd_hist[0]),
      .rd_tap_addr   (tok_rd_tap[0])
   );

   // Row of channel cells; each registers the token and passes it on
   for (genvar c = 0; c < CHANNELS; c++) begin : g_cell
      sfc_cell #(
         .MAX_TAPS (MAX_TAPS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_ctl     (tok_ctl[c]),
         .up_wr_addr (tok_wr_addr[c]),
         .up_rd_hist (tok_rd_hist[c]),
         .up_rd_tap  (tok_rd_tap[c]),
         .tap_wdata  (tap_wd_ff[c]),
         .hist_wdata (hist_wd_ff[c]),
         .bus        (bus_ff[c]),
         .gain       (gain_ff),
         .dn_ctl     (tok_ctl[c+1]),
         .dn_wr_addr (tok_wr_addr[c+1]),
         .dn_rd_hist (tok_rd_hist[c+1]),
         .dn_rd_tap  (tok_rd_tap[c+1]),
         .result     (cell_result[c]),
         .done       (cell_done[c])
      );
   end

   // Output register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_left_ff  <= cell_result[CH_LEFT];
         rsp_right_ff <= cell_result[CH_RIGHT];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = rsp_left_ff;
   assign rsp_out_right = rsp_right_ff;

   // Right cell finishes in the cycle after the left
   assert property (@(posedge clock) disable iff (reset)
      cell_done[CH_LEFT] |=> cell_done[CH_RIGHT])
      else $error("right channel result not one cycle behind left");

   // Last read leaving the row retires into a result a fixed time later
   assert property (@(posedge clock) disable iff (reset)
      (tok_ctl[CHANNELS].rd && tok_ctl[CHANNELS].last) |-> ##DONE_LAG cell_done[CHANNELS-1])
      else $error("row result latency broken");

   // Only one request in flight
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

endmodule

/* verif/stereo_fir_convolver_checker.sv */
// Request/result checker for the stereo FIR convolver: tracks taps, history and registers.
`timescale 1ns / 100ps

module stereo_fir_convolver_checker import sfc_pkg::*; #(
   parameter int unsigned MAX_TAPS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_mode,
   input  logic [INDEX_BITS-1:0]     req_tap_index,
   input  sample_type                req_tap_left,
   input  sample_type                req_tap_right,
   input  sample_type                req_sample_left,
   input  sample_type                req_sample_right,
   input  sample_type                req_bus_left,
   input  sample_type                req_bus_right,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  sample_type                rsp_out_left,
   input  sample_type                rsp_out_right,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int unsigned               error_count,
   output int unsigned               mixes_pending
);

   localparam longint SAT_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_MIN = -SAT_MAX - 1;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } mix_type;

   // Shadow copy of the block's stores and registers
   sample_type            hist_left  [MAX_TAPS];
   sample_type            hist_right [MAX_TAPS];
   sample_type            taps_left  [MAX_TAPS];
   sample_type            taps_right [MAX_TAPS];
   int unsigned           write_pos;
   logic [COUNT_BITS-1:0] tap_count_reg;
   logic [GAIN_BITS-1:0]  gain_reg;

   // Output mixes still owed by the block, oldest first
   mix_type               mix_queue [$];
   int unsigned           errors  = 0;
   int unsigned           pending = 0;

   assign error_count   = errors;
   assign mixes_pending = pending;

   task automatic clear_model();
      int unsigned k;
      for (k = 0; k < MAX_TAPS; k++) begin
         hist_left[k]  = '0;
         hist_right[k] = '0;
         taps_left[k]  = '0;
         taps_right[k] = '0;
      end
      write_pos     = 0;
      tap_count_reg = TAP_COUNT_RESET;
      gain_reg      = GAIN_RESET;
      mix_queue.delete();
   endtask

   // Scale a sum of Q2.30 products by the Q4.12 gain, round half up to 15 fraction bits, add the bus, saturate to Q1.15
   function automatic sample_type scale_and_mix(input longint acc, input sample_type bus);
      longint scaled;
      longint total;
      scaled = (acc * longint'(gain_reg) + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      total  = scaled + longint'(bus);
      if (total > SAT_MAX)
         total = SAT_MAX;
      else if (total < SAT_MIN)
         total = SAT_MIN;
      return sample_type'(total);
   endfunction

   // Apply one accepted request to the shadow state; a sample yields one mix
   task automatic take_request();
      int unsigned len;
      int unsigned pos;
      int unsigned k;
      longint      acc_left;
      longint      acc_right;
      mix_type     mix;
      if (tap_count_reg == 0)
         len = 1;
      else if (tap_count_reg > MAX_TAPS)
         len = MAX_TAPS;
      else
         len = tap_count_reg;

      if (req_mode == MODE_TAP) begin
         if (req_tap_index < MAX_TAPS) begin
            taps_left[req_tap_index]  = req_tap_left;
            taps_right[req_tap_index] = req_tap_right;
         end
      end else begin
         // pointer left past the ring by a shorter tap count restarts at zero
         if (write_pos >= len)
            write_pos = 0;
         hist_left[write_pos]  = req_sample_left;
         hist_right[write_pos] = req_sample_right;

         acc_left  = 0;
         acc_right = 0;
         pos       = write_pos;
         for (k = 0; k < len; k++) begin
            acc_left  += longint'(hist_left[pos]) * longint'(taps_left[k]);
            acc_right += longint'(hist_right[pos]) * longint'(taps_right[k]);
            pos = (pos == 0) ? len - 1 : pos - 1;
         end

         mix.left  = scale_and_mix(acc_left, req_bus_left);
         mix.right = scale_and_mix(acc_right, req_bus_right);
         mix_queue.push_back(mix);

         write_pos = (write_pos + 1 >= len) ? 0 : write_pos + 1;
      end
   endtask

   task automatic check_mix();
      mix_type want;
      if (mix_queue.size() == 0) begin
         $display("%0t: unexpected result: left %0d right %0d",
                  $time, rsp_out_left, rsp_out_right);
         errors++;
      end else begin
         want = mix_queue.pop_front();
         if (rsp_out_left !== want.left) begin
            $display("%0t: out_left mismatch: expected %0d, got %0d",
                     $time, want.left, rsp_out_left);
            errors++;
         end
         if (rsp_out_right !== want.right) begin
            $display("%0t: out_right mismatch: expected %0d, got %0d",
                     $time, want.right, rsp_out_right);
            errors++;
         end
      end
   endtask

   // Everything is sampled on the rising edge, before the block's own updates land
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TAP_COUNT: tap_count_reg = csr_wdata[COUNT_BITS-1:0];
               CSR_GAIN:      gain_reg      = csr_wdata[GAIN_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready)
            check_mix();
         if (req_valid && req_ready)
            take_request();
      end
      pending = mix_queue.size();
   end

endmodule

/* verif/stereo_fir_convolver_core_tb.sv */
// Testbench top for the stereo FIR convolver: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module stereo_fir_convolver_core_tb;
   import sfc_pkg::*;

   localparam int unsigned TAPS_MAX     = 4096;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_ITEMS  = 17;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_mode = MODE_TAP;
   logic [INDEX_BITS-1:0]     req_tap_index = '0;
   sample_type                req_tap_left = '0;
   sample_type                req_tap_right = '0;
   sample_type                req_sample_left = '0;
   sample_type                req_sample_right = '0;
   sample_type                req_bus_left = '0;
   sample_type                req_bus_right = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b1;
   sample_type                rsp_out_left;
   sample_type                rsp_out_right;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_TAP_COUNT;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int unsigned               mismatches;
   int unsigned               mixes_pending;
   int unsigned               cycle_count = 0;
   int unsigned               send_gap_pct = 0;
   int unsigned               rsp_stall_pct = 0;

   stereo_fir_convolver_core #(.MAX_TAPS(TAPS_MAX)) uut (.*);

   stereo_fir_convolver_checker #(.MAX_TAPS(TAPS_MAX)) u_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_mode, .req_tap_index,
      .req_tap_left, .req_tap_right, .req_sample_left, .req_sample_right,
      .req_bus_left, .req_bus_right,
      .rsp_valid, .rsp_ready, .rsp_out_left, .rsp_out_right,
      .csr_wr_en, .csr_index, .csr_wdata,
      .error_count(mismatches),
      .mixes_pending(mixes_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Mostly random audio words, with the extremes mixed in
   function automatic sample_type pick_sample();
      case ($urandom_range(0, 11))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Present one request and hold it until taken; starts and ends on a rising edge
   task automatic send_request(input logic mode, input logic [INDEX_BITS-1:0] idx,
                               input sample_type tl, input sample_type tr,
                               input sample_type sl, input sample_type sr,
                               input sample_type bl, input sample_type br);
      int unsigned gap;
      gap = 0;
      while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_tap_index    <= idx;
      req_tap_left     <= tl;
      req_tap_right    <= tr;
      req_sample_left  <= sl;
      req_sample_right <= sr;
      req_bus_left     <= bl;
      req_bus_right    <= br;
      do @(negedge clock); while (req_ready !== 1'b1);
      @(posedge clock);
   endtask

   task automatic send_tap(input logic [INDEX_BITS-1:0] idx,
                           input sample_type tl, input sample_type tr);
      send_request(MODE_TAP, idx, tl, tr,
                   pick_sample(), pick_sample(), pick_sample(), pick_sample());
   endtask

   task automatic send_sample(input sample_type sl, input sample_type sr,
                              input sample_type bl, input sample_type br);
      send_request(MODE_SAMPLE, INDEX_BITS'($urandom), pick_sample(), pick_sample(),
                   sl, sr, bl, br);
   endtask

   // Let the block run dry: every mix returned, then room for a trailing tap write
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (mixes_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [COUNT_BITS-1:0] count,
                                 input logic [GAIN_BITS-1:0] gain);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TAP_COUNT;
      csr_wdata <= CSR_DATA_BITS'(count);
      @(posedge clock);
      csr_index <= CSR_GAIN;
      csr_wdata <= CSR_DATA_BITS'(gain);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(input int unsigned sender_pct, input int unsigned stall_pct);
      send_gap_pct  = sender_pct;
      rsp_stall_pct <= stall_pct;
   endtask

   // One setting, a run of tap writes, then samples; some noise on top
   task automatic random_phase(input int unsigned n_items);
      int unsigned          pick;
      int unsigned          count;
      int unsigned          len;
      int unsigned          tap_writes;
      int unsigned          k;
      logic [GAIN_BITS-1:0] gain;
      pick  = $urandom_range(0, 9);
      count = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      case ($urandom_range(0, 7))
         0:       gain = GAIN_RESET;
         1:       gain = 16'hFFFF;
         2:       gain = 16'h0000;
         3:       gain = GAIN_BITS'($urandom);
         default: gain = GAIN_BITS'($urandom_range(0, 12288));
      endcase
      len        = (count == 0) ? 1 : count;
      tap_writes = $urandom_range(0, len);
      if (tap_writes > n_items / 2)
         tap_writes = n_items / 2;

      settle();
      write_settings(COUNT_BITS'(count), gain);
      for (k = 0; k < n_items; k++) begin
         if ($urandom_range(0, 99) < 15)
            send_request(($urandom_range(0, 1) != 0) ? MODE_SAMPLE : MODE_TAP,
                         INDEX_BITS'($urandom), pick_sample(), pick_sample(),
                         pick_sample(), pick_sample(), pick_sample(), pick_sample());
         else if (k < tap_writes)
            send_tap(INDEX_BITS'(k), pick_sample(), pick_sample());
         else
            send_sample(pick_sample(), pick_sample(), pick_sample(), pick_sample());
      end
   endtask

   initial begin
      int unsigned p;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // the block clears its stores before it takes requests
      do @(negedge clock); while (req_ready !== 1'b1);
      @(posedge clock);

      // Directed: four taps at unity gain, full-scale taps and samples
      write_settings(13'd4, GAIN_RESET);
      send_tap(12'd0, 16'sh7FFF, 16'sh8000);
      send_tap(12'd1, 16'sh8000, 16'sh7FFF);
      send_tap(12'd2, 16'sh4000, 16'shFFFF);
      send_tap(12'd3, 16'sh0001, 16'sh0000);
      send_tap(12'd4095, 16'sh8000, 16'sh8000);   // top entry, unused for now
      send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000);
      send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
      send_sample(16'sh0001, 16'shFFFF, 16'sh0064, 16'shFF9C);
      send_sample(16'sh5555, 16'shAAAA, 16'sh0000, 16'sh0000);

      // Tap count zero acts as one; the pointer now sits past the shorter ring
      settle();
      write_settings(13'd0, 16'hFFFF);
      send_sample(16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000);
      send_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);

      // Oversized tap count clamps to the full memory, then the exact maximum
      settle();
      write_settings(13'd8191, 16'h0001);
      send_sample(16'sh7FFF, 16'sh8000, 16'sh1234, 16'shEDCB);
      settle();
      write_settings(13'd4096, 16'h0000);
      send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);

      // Random phases, cycling through the idling patterns
      for (p = 0; p < PHASES; p++) begin
         case (p % 4)
            0:       set_idling(0, 0);
            1:       set_idling(48, 0);
            2:       set_idling(0, 48);
            default: set_idling(15, 15);
         endcase
         random_phase(PHASE_ITEMS);
      end

      settle();
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* stereo_fir_convolver_core.f */
rtl/sfc_pkg.sv
rtl/sfc_cell.sv
rtl/sfc_seq.sv
rtl/stereo_fir_convolver_core.sv
verif/stereo_fir_convolver_checker.sv
verif/stereo_fir_convolver_core_tb.sv
